// File: src/samstk_pkg.sv
// Shared types, sizes and codes for the shared-array multi-stack block.
package samstk_pkg;

  // Geometry of the shared slot memory.
  localparam int SLOTS      = 8;
  localparam int STACKS     = 4;
  localparam int DATA_WIDTH = 32;

  // Port widths fixed by the item format.
  localparam int CMD_W   = 1;
  localparam int ID_W    = 2;
  localparam int IO_W    = 32;
  localparam int SIZE_W  = 4;

  // Derived internal widths.
  localparam int CNT_W  = $clog2(SLOTS + 1);   // holds 0..SLOTS
  localparam int SUM_W  = CNT_W + 1;           // base plus count without overflow
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int SID_W  = $clog2(STACKS);
  localparam int J_W    = $clog2(STACKS + 1);  // stack walker may step one past the last

  // Operation codes on the cmd field.
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UP_SEL,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_SEL,
    ST_DN_RD,
    ST_DN_WR,
    ST_PUSH_WR,
    ST_POP_RD,
    ST_RESP
  } samstk_state_e;

  // Which slot address the datapath drives onto the memory.
  typedef enum logic [1:0] {
    ADDR_LO,    // base[j] + k - 1
    ADDR_HI,    // base[j] + k
    ADDR_PUSH,  // base[s] + count[s]
    ADDR_POP    // base[s] + count[s] - 1
  } samstk_addr_sel_e;

  typedef struct packed {
    logic             load;
    logic             j_up_init;
    logic             j_dn_init;
    logic             j_inc;
    logic             j_dec;
    logic             k_load;
    logic             k_clear;
    logic             k_inc;
    logic             k_dec;
    logic             base_inc;
    logic             base_dec;
    logic             mem_re;
    logic             mem_we;
    samstk_addr_sel_e addr_sel;
    logic             wr_from_in;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             ok_set;
  } samstk_ctl_t;

  typedef struct packed {
    logic is_pop;
    logic sid_ok;
    logic s_full;
    logic s_empty;
    logic j_above_s;
    logic j_full;
    logic j_gap;
    logic k_zero;
    logic k_at_cnt;
  } samstk_status_t;

endpackage

// File: src/samstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module samstk_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/samstk_ctrl.sv
// Controller state machine that sequences pushes, pops and stack shifts.
module samstk_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  samstk_pkg::samstk_status_t status_i,
  output samstk_pkg::samstk_ctl_t    ctl_o,
  output logic                       busy_o,
  output logic                       valid_o
);

  import samstk_pkg::*;

  samstk_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.sid_ok) begin
          state_d = ST_RESP;
        end else if (status_i.is_pop) begin
          state_d = status_i.s_empty ? ST_RESP : ST_POP_RD;
        end else begin
          state_d = status_i.s_full ? ST_UP_SEL : ST_PUSH_WR;
        end
      end
      ST_UP_SEL: begin
        if (!status_i.j_above_s) begin
          state_d = status_i.s_full ? ST_DN_SEL : ST_PUSH_WR;
        end else if (!status_i.j_full) begin
          state_d = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        state_d = status_i.k_zero ? ST_UP_SEL : ST_UP_WR;
      end
      ST_UP_WR: begin
        state_d = ST_UP_RD;
      end
      ST_DN_SEL: begin
        if (status_i.j_above_s) begin
          state_d = status_i.s_full ? ST_RESP : ST_PUSH_WR;
        end else if (status_i.j_gap) begin
          state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        state_d = status_i.k_at_cnt ? ST_DN_SEL : ST_DN_WR;
      end
      ST_DN_WR: begin
        state_d = ST_DN_RD;
      end
      ST_PUSH_WR: begin
        state_d = ST_RESP;
      end
      ST_POP_RD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl_o          = '0;
    ctl_o.addr_sel = ADDR_LO;
    case (state_q)
      ST_IDLE: begin
        ctl_o.load = start_i;
      end
      ST_CHECK: begin
        if (status_i.sid_ok && !status_i.is_pop && status_i.s_full) begin
          ctl_o.j_up_init = 1'b1;
        end
      end
      ST_UP_SEL: begin
        if (!status_i.j_above_s) begin
          ctl_o.j_dn_init = status_i.s_full;
        end else if (status_i.j_full) begin
          ctl_o.j_dec = 1'b1;
        end else begin
          ctl_o.k_load = 1'b1;
        end
      end
      ST_UP_RD: begin
        if (status_i.k_zero) begin
          ctl_o.base_inc = 1'b1;
          ctl_o.j_dec    = 1'b1;
        end else begin
          ctl_o.mem_re   = 1'b1;
          ctl_o.addr_sel = ADDR_LO;
        end
      end
      ST_UP_WR: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = ADDR_HI;
        ctl_o.k_dec    = 1'b1;
      end
      ST_DN_SEL: begin
        if (!status_i.j_above_s) begin
          if (status_i.j_gap) begin
            ctl_o.k_clear = 1'b1;
          end else begin
            ctl_o.j_inc = 1'b1;
          end
        end
      end
      ST_DN_RD: begin
        if (status_i.k_at_cnt) begin
          ctl_o.base_dec = 1'b1;
          ctl_o.j_inc    = 1'b1;
        end else begin
          ctl_o.mem_re   = 1'b1;
          ctl_o.addr_sel = ADDR_HI;
        end
      end
      ST_DN_WR: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = ADDR_LO;
        ctl_o.k_inc    = 1'b1;
      end
      ST_PUSH_WR: begin
        ctl_o.mem_we     = 1'b1;
        ctl_o.addr_sel   = ADDR_PUSH;
        ctl_o.wr_from_in = 1'b1;
        ctl_o.cnt_inc    = 1'b1;
        ctl_o.ok_set     = 1'b1;
      end
      ST_POP_RD: begin
        ctl_o.mem_re   = 1'b1;
        ctl_o.addr_sel = ADDR_POP;
        ctl_o.cnt_dec  = 1'b1;
        ctl_o.ok_set   = 1'b1;
      end
      default: begin
        ctl_o.load = 1'b0;
      end
    endcase
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_RESP);

  // The result strobe lasts a single cycle.
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // After a result the block is free again.
  a_resp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o)
    else $error("block still busy after its result");

endmodule

// File: src/samstk_dp.sv
// Datapath: stack bases and counts, item registers, slot memory and address logic.
module samstk_dp (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  samstk_pkg::samstk_ctl_t                    ctl_i,
  input  logic [samstk_pkg::CMD_W-1:0]               cmd_i,
  input  logic [samstk_pkg::ID_W-1:0]                stack_id_i,
  input  logic signed [samstk_pkg::IO_W-1:0]         data_in_i,
  output samstk_pkg::samstk_status_t                 status_o,
  output logic                                       ok_o,
  output logic signed [samstk_pkg::IO_W-1:0]         data_out_o,
  output logic [samstk_pkg::SIZE_W-1:0]              stack_size_o,
  output logic [samstk_pkg::SIZE_W-1:0]              total_size_o
);

  import samstk_pkg::*;

  logic [CNT_W-1:0]      base_q  [STACKS];
  logic [CNT_W-1:0]      base_d  [STACKS];
  logic [CNT_W-1:0]      count_q [STACKS];
  logic [CNT_W-1:0]      count_d [STACKS];
  logic [CNT_W-1:0]      total_q, total_d;
  logic                  ok_q;

  logic [SID_W-1:0]      s_q;
  logic                  sid_ok_q;
  logic                  is_pop_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [J_W-1:0]        j_q;
  logic [CNT_W-1:0]      k_q;

  logic [SID_W-1:0]      jidx, jm1, s_nxt, j_nxt;
  logic [CNT_W-1:0]      ub_s, ub_j;
  logic [SUM_W-1:0]      top_s, top_j, below_top;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // Item registers, captured when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      s_q      <= SID_W'(stack_id_i);
      sid_ok_q <= (32'(stack_id_i) < STACKS);
      is_pop_q <= (cmd_i == CMD_POP);
      data_q   <= DATA_WIDTH'($unsigned(data_in_i));
    end
  end

  // Stack walker and move counter.
  always_ff @(posedge clk_i) begin
    if (ctl_i.j_up_init) begin
      j_q <= J_W'(STACKS - 1);
    end else if (ctl_i.j_dn_init) begin
      j_q <= J_W'(1);
    end else if (ctl_i.j_inc) begin
      j_q <= j_q + J_W'(1);
    end else if (ctl_i.j_dec) begin
      j_q <= j_q - J_W'(1);
    end

    if (ctl_i.k_load) begin
      k_q <= count_q[jidx];
    end else if (ctl_i.k_clear) begin
      k_q <= '0;
    end else if (ctl_i.k_inc) begin
      k_q <= k_q + CNT_W'(1);
    end else if (ctl_i.k_dec) begin
      k_q <= k_q - CNT_W'(1);
    end
  end

  assign jidx  = j_q[SID_W-1:0];
  assign jm1   = jidx - SID_W'(1);
  assign s_nxt = s_q + SID_W'(1);
  assign j_nxt = jidx + SID_W'(1);

  // Next base and count values.
  always_comb begin
    for (int i = 0; i < STACKS; i++) begin
      base_d[i]  = base_q[i];
      count_d[i] = count_q[i];
    end
    if (ctl_i.base_inc) base_d[jidx] = base_q[jidx] + CNT_W'(1);
    if (ctl_i.base_dec) base_d[jidx] = base_q[jidx] - CNT_W'(1);
    if (ctl_i.cnt_inc)  count_d[s_q] = count_q[s_q] + CNT_W'(1);
    if (ctl_i.cnt_dec)  count_d[s_q] = count_q[s_q] - CNT_W'(1);
  end

  always_comb begin
    total_d = total_q;
    if (ctl_i.cnt_inc) total_d = total_q + CNT_W'(1);
    if (ctl_i.cnt_dec) total_d = total_q - CNT_W'(1);
  end

  // Each stack starts at its equal share of the slot memory.
  for (genvar i = 0; i < STACKS; i++) begin : g_stack
    localparam int BaseRst = (i * SLOTS) / STACKS;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        base_q[i]  <= CNT_W'(BaseRst);
        count_q[i] <= '0;
      end else begin
        base_q[i]  <= base_d[i];
        count_q[i] <= count_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      total_q <= total_d;
      if (ctl_i.load) begin
        ok_q <= 1'b0;
      end else if (ctl_i.ok_set) begin
        ok_q <= 1'b1;
      end
    end
  end

  // Room limits: a stack ends where the next one begins, the last one at the memory end.
  assign ub_s = (s_q == SID_W'(STACKS - 1)) ? CNT_W'(SLOTS) : base_q[s_nxt];
  assign ub_j = (jidx == SID_W'(STACKS - 1)) ? CNT_W'(SLOTS) : base_q[j_nxt];

  assign top_s     = {1'b0, base_q[s_q]} + {1'b0, count_q[s_q]};
  assign top_j     = {1'b0, base_q[jidx]} + SUM_W'(k_q);
  assign below_top = {1'b0, base_q[jm1]} + {1'b0, count_q[jm1]};

  always_comb begin
    status_o.is_pop    = is_pop_q;
    status_o.sid_ok    = sid_ok_q;
    status_o.s_full    = (top_s >= {1'b0, ub_s});
    status_o.s_empty   = (count_q[s_q] == '0);
    status_o.j_above_s = (j_q > J_W'(s_q));
    status_o.j_full    = (({1'b0, base_q[jidx]} + {1'b0, count_q[jidx]}) >= {1'b0, ub_j});
    status_o.j_gap     = ({1'b0, base_q[jidx]} > below_top);
    status_o.k_zero    = (k_q == '0);
    status_o.k_at_cnt  = (k_q == count_q[jidx]);
  end

  // Slot memory access.
  always_comb begin
    case (ctl_i.addr_sel)
      ADDR_LO:   mem_addr = ADDR_W'(top_j - SUM_W'(1));
      ADDR_HI:   mem_addr = ADDR_W'(top_j);
      ADDR_PUSH: mem_addr = ADDR_W'(top_s);
      ADDR_POP:  mem_addr = ADDR_W'(top_s - SUM_W'(1));
      default:   mem_addr = '0;
    endcase
  end

  assign mem_we    = ctl_i.mem_we;
  assign mem_re    = ctl_i.mem_re;
  assign mem_wdata = ctl_i.wr_from_in ? data_q : mem_rdata;

  samstk_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // Result fields; the popped value sits in the memory's read register.
  assign ok_o         = ok_q;
  assign data_out_o   = (ok_q && is_pop_q) ? IO_W'(mem_rdata) : '0;
  assign stack_size_o = sid_ok_q ? SIZE_W'(count_q[s_q]) : '0;
  assign total_size_o = SIZE_W'(total_q);

  // One address serves both ports, so a cycle reads or writes, never both.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.mem_we && ctl_i.mem_re))
    else $error("slot memory read and written in the same cycle");

  // No stack ever grows past the start of the next one or past the memory end.
  for (genvar i = 0; i < STACKS; i++) begin : g_bound
    if (i == STACKS - 1) begin : g_last
      a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
        ({1'b0, base_q[i]} + {1'b0, count_q[i]}) <= SUM_W'(SLOTS))
        else $error("last stack runs past the memory end");
    end else begin : g_mid
      a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
        ({1'b0, base_q[i]} + {1'b0, count_q[i]}) <= {1'b0, base_q[i+1]})
        else $error("stack overlaps the next stack");
    end
  end

endmodule

// File: src/shared_array_multi_stack.sv
// Top level of the shared-array multi-stack block: controller plus datapath.
//
//   Channel   Handshake            Fields
//   -------   ------------------   -----------------------------------------
//   item in   start_i / busy_o     cmd_i, stack_id_i, data_in_i
//   result    valid_o (strobe)     ok_o, data_out_o, stack_size_o, total_size_o
//
// An item is accepted at a rising edge where start_i is high and busy_o is low.
// A pop or a push with room passes from one accept to the next through a check
// state, one memory state, the result state and the idle state. A pop from an
// empty stack skips the memory state. A push to a full stack additionally
// walks the neighboring stacks: each stack is examined in turn, and each stack
// that moves has its entries copied one by one (a memory read, then a memory
// write through the single slot RAM port) and then gets its base updated.
// If the walk finds no room, the push fails and goes straight to the result
// cycle without the memory write.
// Reset is asynchronous and active low; it returns every stack to its equal
// share of the memory, empty. Slot contents are not cleared, since only live
// entries are ever read. The result is shown for exactly one cycle while
// valid_o is high; the receiver cannot stall it, and busy_o stays high until
// the result cycle is over.
module shared_array_multi_stack (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [samstk_pkg::CMD_W-1:0]          cmd_i,
  input  logic [samstk_pkg::ID_W-1:0]           stack_id_i,
  input  logic signed [samstk_pkg::IO_W-1:0]    data_in_i,
  output logic                                  valid_o,
  output logic                                  ok_o,
  output logic signed [samstk_pkg::IO_W-1:0]    data_out_o,
  output logic [samstk_pkg::SIZE_W-1:0]         stack_size_o,
  output logic [samstk_pkg::SIZE_W-1:0]         total_size_o
);

  import samstk_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  samstk_ctl_t    ctl;
  samstk_status_t status;

  samstk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  // The datapath holds the bases, counts and slot memory, and drives the result fields.
  samstk_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (cmd_i),
    .stack_id_i   (stack_id_i),
    .data_in_i    (data_in_i),
    .status_o     (status),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .stack_size_o (stack_size_o),
    .total_size_o (total_size_o)
  );

endmodule

// File: bench/stack_check_pkg.sv
// Scoreboard class that predicts and checks results of the shared-array multi-stack block.
`timescale 1ns / 100ps
package stack_check_pkg;
  import samstk_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [IO_W-1:0]   data;
    logic [SIZE_W-1:0] stack_size;
    logic [SIZE_W-1:0] total_size;
  } stack_result_t;

  class stack_scoreboard;
    logic [DATA_WIDTH-1:0] slot_mem [SLOTS];
    int                    base_of  [STACKS];
    int                    depth_of [STACKS];
    stack_result_t         expected_q [$];
    int unsigned           errors;

    function new();
      for (int i = 0; i < STACKS; i++) begin
        base_of[i]  = (i * SLOTS) / STACKS;
        depth_of[i] = 0;
      end
      foreach (slot_mem[i]) slot_mem[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A stack is full once its top reaches the base of the next stack, or the memory end for the last stack.
    function bit is_full(int s);
      int upper;
      upper = (s + 1 < STACKS) ? base_of[s + 1] : SLOTS;
      return base_of[s] + depth_of[s] >= upper;
    endfunction

    // Applies one accepted item to the private copy of the stacks and queues
    // the result it must produce.
    function void note_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] sid,
                            logic [IO_W-1:0] value);
      stack_result_t r;
      int            s;
      int            pos;
      int            src;
      int            total;
      r = '0;
      s = int'(sid);
      if (s < STACKS) begin
        if (cmd == CMD_PUSH) begin
          if (is_full(s)) begin
            // Make room by moving the higher stacks up, topmost first.
            for (int i = STACKS - 1; i > s; i--) begin
              if (!is_full(i)) begin
                for (int k = depth_of[i]; k > 0; k--) begin
                  src = base_of[i] + k - 1;
                  if (src + 1 < SLOTS) slot_mem[src + 1] = slot_mem[src];
                end
                base_of[i]++;
              end
            end
            // Then pull stacks 1 up to the addressed one down into gaps.
            if (is_full(s)) begin
              for (int i = 1; i <= s; i++) begin
                if (base_of[i] > base_of[i - 1] + depth_of[i - 1]) begin
                  for (int k = 0; k < depth_of[i]; k++) begin
                    src = base_of[i] + k;
                    if (src >= 1 && src < SLOTS) slot_mem[src - 1] = slot_mem[src];
                  end
                  base_of[i]--;
                end
              end
            end
          end
          if (!is_full(s)) begin
            pos = base_of[s] + depth_of[s];
            if (pos < SLOTS) begin
              slot_mem[pos] = value[DATA_WIDTH-1:0];
              depth_of[s]++;
              r.ok = 1'b1;
            end
          end
        end else if (depth_of[s] > 0) begin
          depth_of[s]--;
          pos = base_of[s] + depth_of[s];
          if (pos < SLOTS) r.data = IO_W'(slot_mem[pos]);
          r.ok = 1'b1;
        end
        r.stack_size = SIZE_W'(depth_of[s]);
      end
      total = 0;
      for (int i = 0; i < STACKS; i++) total += depth_of[i];
      r.total_size = SIZE_W'(total);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic ok, logic [IO_W-1:0] data,
                               logic [SIZE_W-1:0] stack_size,
                               logic [SIZE_W-1:0] total_size);
      stack_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no item waiting: ok=%0d data=%h size=%0d total=%0d",
                   $realtime, ok, data, stack_size, total_size);
        return;
      end
      exp_r = expected_q.pop_front();
      if (ok !== exp_r.ok || data !== exp_r.data || stack_size !== exp_r.stack_size ||
          total_size !== exp_r.total_size) begin
        errors++;
        if (errors <= 10)
          $display("%0t: wrong result: expected ok=%0d data=%h size=%0d total=%0d, got ok=%0d data=%h size=%0d total=%0d",
                   $realtime, exp_r.ok, exp_r.data, exp_r.stack_size, exp_r.total_size,
                   ok, data, stack_size, total_size);
      end
    endfunction
  endclass

endpackage

// File: bench/tb.sv
// Top-level testbench for the shared-array multi-stack block.
`timescale 1ns / 100ps
module tb;
  import samstk_pkg::*;
  import stack_check_pkg::*;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start_i    = 1'b0;
  logic [CMD_W-1:0]         cmd_i      = CMD_PUSH;
  logic [ID_W-1:0]          stack_id_i = '0;
  logic signed [IO_W-1:0]   data_in_i  = '0;
  logic                     busy_o;
  logic                     valid_o;
  logic                     ok_o;
  logic signed [IO_W-1:0]   data_out_o;
  logic [SIZE_W-1:0]        stack_size_o;
  logic [SIZE_W-1:0]        total_size_o;

  // When set, items are sent back to back; otherwise each item waits a
  // random number of cycles before start is raised.
  bit burst_mode = 1'b0;

  stack_scoreboard sb = new();

  shared_array_multi_stack i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .stack_id_i   (stack_id_i),
    .data_in_i    (data_in_i),
    .valid_o      (valid_o),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .stack_size_o (stack_size_o),
    .total_size_o (total_size_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // All checking happens at the rising edge. The result is checked before the
  // item accepted at the same edge is noted, although the block never accepts
  // an item while the result of the previous one is still pending.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(ok_o, data_out_o, stack_size_o, total_size_o);
      if (start_i && !busy_o) sb.note_item(cmd_i, stack_id_i, data_in_i);
    end
  end

  // For a positive count, drops start and lets that number of falling edges pass.
  task automatic idle_cycles(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Presents one item after an optional gap and holds it until the block
  // takes it. Returns on the falling edge after the accepting rising edge, so
  // the caller may present the next item at once without lowering start.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] sid, logic [IO_W-1:0] value);
    idle_cycles(burst_mode ? 0 : $urandom_range(0, 12));
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    stack_id_i <= sid;
    data_in_i  <= value;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every result owed so far has come back. At
  // least one falling edge passes with start low, so start is never lowered
  // and raised in the same time step.
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [IO_W-1:0]  extreme_vals [8];
    int               push_pct;
    int               hot_sid;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  sid;
    logic [IO_W-1:0]  value;

    extreme_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Popping every stack while all are empty must fail.
    for (int s = 0; s < STACKS; s++) issue(CMD_POP, ID_W'(s), $urandom());
    // Pushing eight values onto stack 0 overflows its share again and again,
    // so the higher stacks are pushed up until the whole memory belongs to it.
    for (int i = 0; i < SLOTS; i++) issue(CMD_PUSH, '0, extreme_vals[i]);
    // With the memory full, pushes fail both on stack 0 and on a stack that
    // has to try pulling lower stacks down first.
    issue(CMD_PUSH, 2'd0, 32'h1234_5678);
    issue(CMD_PUSH, 2'd2, 32'h8765_4321);
    // Two pops free slots at the top of stack 0, which pulls the empty stacks
    // above it down when the last stack is pushed.
    issue(CMD_POP, 2'd0, '0);
    issue(CMD_POP, 2'd0, '0);
    issue(CMD_PUSH, 2'd3, 32'hdead_beef);
    issue(CMD_PUSH, 2'd3, 32'h0bad_cafe);
    issue(CMD_PUSH, 2'd1, 32'h0f0f_0f0f);
    // Popping stack 3 empties it; the third pop has nothing left.
    repeat (3) issue(CMD_POP, 2'd3, '0);

    // The sender waits here for the directed part to finish completely.
    drain();

    // Random part: phases of thirty items. Each phase leans toward pushes or
    // pops and often toward one stack, so the memory swings between nearly
    // empty and full and every shifting path gets exercised.
    for (int phase = 0; phase < 31; phase++) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 20;
        1:       push_pct = 50;
        2:       push_pct = 70;
        default: push_pct = 90;
      endcase
      hot_sid    = $urandom_range(0, STACKS - 1);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 30; n++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        sid = $urandom_range(0, 1) ? ID_W'(hot_sid) : ID_W'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7fff_ffff;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom();
        endcase
        issue(cmd, sid, value);
      end
      // Now and then the sender stops until the block has answered everything.
      if (phase % 5 == 4) drain();
    end

    drain();
    // The wait below covers the longest shifting walk, so a stray result
    // would show up before the verdict.
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run of this stimulus.
  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: shared_array_multi_stack.f
src/samstk_pkg.sv
src/samstk_ram.sv
src/samstk_ctrl.sv
src/samstk_dp.sv
src/shared_array_multi_stack.sv
bench/stack_check_pkg.sv
bench/tb.sv
